// File: sv/stable_max_priority_queue_defines.svh
// assertion macros for the stable max priority queue
// used by the top level; no other dependencies
`ifndef STABLE_MAX_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_MAX_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("priority queue check failed");

// next-cycle implication, disabled while in reset
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("priority queue check failed");

`endif

// File: sv/spq_pkg.sv
// shared types and codes for the stable max priority queue
// no dependencies
`default_nettype none

package spq_pkg;

    localparam int unsigned OCC_W = 7;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic [1:0] STATUS_INSERTED  = 2'd0;
    localparam logic [1:0] STATUS_EXTRACTED = 2'd1;
    localparam logic [1:0] STATUS_EMPTY     = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    typedef struct packed {
        logic        op;
        logic [15:0] tag;
        logic [15:0] priority_req;
    } spq_req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [15:0]      out_tag;
        logic [OCC_W-1:0] occupancy;
    } spq_rsp_t;

    typedef struct packed {
        logic [15:0] prio;
        logic [15:0] tag;
        logic [31:0] arrival;
    } spq_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_LAST
    } spq_state_t;

endpackage

`default_nettype wire

// File: sv/spq_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module spq_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/stable_max_priority_queue.sv
// Bounded max-priority queue, stable among equal priorities. For an insert, an
// extract on an empty queue and an insert on a full queue, the response is
// registered at the request transfer. In an extract, one comparator walks the n
// entries held through the single read port of the entry ram, one per cycle,
// and the last entry is then moved into the freed slot. Entry storage needs no
// clearing after reset. A new request is taken while the previous response is
// being taken in the same cycle.
// depends on spq_pkg, spq_ram and stable_max_priority_queue_defines.svh
`default_nettype none
`include "stable_max_priority_queue_defines.svh"

module stable_max_priority_queue
    import spq_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire spq_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output spq_rsp_t      rsp
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    spq_state_t   state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   arrival_reg, arrival_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          rd_valid_reg, rd_valid_next;
    logic [AW-1:0] rd_idx_reg;
    spq_entry_t    best_reg, best_next;
    logic [AW-1:0] best_idx_reg, best_idx_next;
    logic          rsp_valid_reg, rsp_valid_next;
    spq_rsp_t      rsp_reg, rsp_next;

    logic          req_xfer;
    logic          full;
    logic          empty;
    logic [CW-1:0] count_dec;
    logic [AW-1:0] last_idx;
    logic          take;
    logic          rsp_load;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    spq_entry_t    ram_wdata;
    logic [AW-1:0] ram_raddr;
    spq_entry_t    ram_rdata;

    spq_ram #(
        .WIDTH($bits(spq_entry_t)),
        .DEPTH(CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign req_xfer  = req_valid && req_ready;
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign count_dec = count_reg - CW'(1);
    assign last_idx  = count_dec[AW-1:0];

    // first candidate is always taken; a later one replaces the best on higher priority, or earlier stamp on a tie
    assign take = rd_valid_reg
                  && ((rd_idx_reg == '0)
                      || (ram_rdata.prio > best_reg.prio)
                      || ((ram_rdata.prio == best_reg.prio)
                          && (ram_rdata.arrival < best_reg.arrival)));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer && (req.op == OP_EXTRACT) && !empty)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == last_idx)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_LAST;
            end
            ST_LAST:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        arrival_next   = arrival_reg;
        idx_next       = idx_reg;
        rd_valid_next  = 1'b0;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        rsp_load       = 1'b0;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[AW-1:0];
        ram_wdata      = '{prio: req.priority_req, tag: req.tag, arrival: arrival_reg};
        ram_raddr      = idx_reg;

        if (take)
        begin
            best_next     = ram_rdata;
            best_idx_next = rd_idx_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (req_xfer)
                begin
                    if (req.op == OP_INSERT)
                    begin
                        rsp_load = 1'b1;
                        if (full)
                        begin
                            rsp_next = '{status: STATUS_FULL, out_tag: '0,
                                         occupancy: OCC_W'(count_reg)};
                        end
                        else
                        begin
                            ram_we       = 1'b1;
                            count_next   = count_reg + CW'(1);
                            arrival_next = arrival_reg + 32'd1;
                            rsp_next     = '{status: STATUS_INSERTED, out_tag: '0,
                                             occupancy: OCC_W'(count_next)};
                        end
                    end
                    else if (empty)
                    begin
                        rsp_load = 1'b1;
                        rsp_next = '{status: STATUS_EMPTY, out_tag: '0,
                                     occupancy: OCC_W'(count_reg)};
                    end
                end
            end
            ST_SCAN:
            begin
                ram_raddr     = idx_reg;
                rd_valid_next = 1'b1;
                idx_next      = idx_reg + AW'(1);
            end
            ST_DRAIN:
            begin
                // fetch the last entry to fill the freed slot
                ram_raddr = last_idx;
            end
            ST_LAST:
            begin
                ram_we       = 1'b1;
                ram_waddr    = best_idx_reg;
                ram_wdata    = ram_rdata;
                count_next   = count_dec;
                arrival_next = arrival_reg + 32'd1;
                rsp_load     = 1'b1;
                rsp_next     = '{status: STATUS_EXTRACTED, out_tag: best_reg.tag,
                                 occupancy: OCC_W'(count_dec)};
            end
            default:
            begin
                idx_next = '0;
            end
        endcase

        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            arrival_reg   <= '0;
            idx_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            arrival_reg   <= arrival_next;
            idx_reg       <= idx_next;
            rd_valid_reg  <= rd_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= idx_reg;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `SPQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(CAPACITY))
    `SPQ_ASSERT_NOW(a_best_in_range, clk, rst_n, state_reg == ST_LAST,
                    (best_idx_reg <= last_idx) && !empty)
    `SPQ_ASSERT_NEXT(a_extract_starts, clk, rst_n,
                     req_xfer && (req.op == OP_EXTRACT) && !empty,
                     (state_reg == ST_SCAN) && !rsp_valid_reg)
    `SPQ_ASSERT_NEXT(a_insert_counts, clk, rst_n,
                     req_xfer && (req.op == OP_INSERT) && !full,
                     (count_reg == $past(count_reg) + CW'(1)) && rsp_valid_reg)

endmodule

`default_nettype wire
